// File: hdl/sample_deglitch_filter_top_macros.svh
// Assertion macros for the sample deglitch filter.
// Included by the top level; expects clk and arst_n in scope.
`ifndef SAMPLE_DEGLITCH_FILTER_TOP_MACROS_SVH
`define SAMPLE_DEGLITCH_FILTER_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define DGF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DGF_ASSERT_NEXT(label, ante, cons, msg) \
	`DGF_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: hdl/dgf_pkg.sv
// Shared types and constants for the sample deglitch filter.
// No dependencies.
`default_nettype none

package dgf_pkg;

	localparam int CNT_WIDTH = 16;

	typedef logic [CNT_WIDTH-1:0] count_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_LENGTH = 2'd1,
		REG_LEVEL  = 2'd2,
		REG_INIT   = 2'd3
	} reg_idx_t;

	localparam logic [1:0] MODE_ABOVE = 2'd0;
	localparam logic [1:0] MODE_BOTH  = 2'd1;
	localparam logic [1:0] MODE_BELOW = 2'd2;

	localparam count_t LENGTH_RESET = count_t'(4);

	typedef struct packed {
		logic [1:0] mode;
		count_t     length_th;
	} cfg_t;

endpackage

`default_nettype wire

// File: hdl/dgf_stream_if.sv
// Valid/ready stream channel carrying one signed sample per beat.
// Depends on nothing; used by the top level of the deglitch filter.
`default_nettype none

interface dgf_stream_if #(parameter int WIDTH = 16);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/dgf_step.sv
// Next-state and output decision for one sample of the deglitch filter.
// Depends on dgf_pkg.
`default_nettype none

module dgf_step #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  dgf_pkg::cfg_t                   cfg,
	input  logic signed [SAMPLE_WIDTH-1:0]  level_th,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample,
	input  logic signed [SAMPLE_WIDTH-1:0]  held,
	input  dgf_pkg::count_t                 run_count,
	output logic signed [SAMPLE_WIDTH-1:0]  result,
	output logic signed [SAMPLE_WIDTH-1:0]  held_nxt,
	output dgf_pkg::count_t                 run_count_nxt
);
	import dgf_pkg::*;

	logic   glitch;
	logic   pass;
	count_t count_inc;

	assign count_inc = (run_count == {CNT_WIDTH{1'b1}}) ? run_count : run_count + count_t'(1);
	assign pass = (count_inc >= cfg.length_th);

	always_comb begin
		case (cfg.mode)
			MODE_ABOVE: glitch = (sample > level_th);
			MODE_BOTH: glitch = ((sample > level_th) && (held < level_th)) ||
				((sample < level_th) && (held > level_th));
			MODE_BELOW: glitch = (sample < level_th);
			default: glitch = (sample < level_th);
		endcase
	end

	always_comb begin
		result        = sample;
		held_nxt      = sample;
		run_count_nxt = '0;
		if (glitch) begin
			run_count_nxt = count_inc;
			held_nxt      = held;
			if (!pass) begin
				result = held;
			end else if (cfg.mode == MODE_BOTH) begin
				held_nxt      = sample;
				run_count_nxt = '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/sample_deglitch_filter_top.sv
// Sample deglitch filter: an accepted input beat enters the input register and then, when the
// output can take it, the result register; throughput is one beat per cycle unless the output
// stalls. The result register drives sample_out; the held level and run counter update with it.
// While a result waits, the input register takes one more beat and then the input stalls.
// Reset clears the run counter, held level and level threshold to zero, mode to 0 and the length
// threshold to 4. Depends on dgf_pkg, dgf_stream_if, dgf_step and the assertion macro header.
`default_nettype none

`include "sample_deglitch_filter_top_macros.svh"

module sample_deglitch_filter_top #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dgf_stream_if.sink            sample_in,
	dgf_stream_if.source          sample_out,
	input  logic                  cfg_we,
	input  dgf_pkg::reg_idx_t     cfg_index,
	input  logic [((SAMPLE_WIDTH > dgf_pkg::CNT_WIDTH) ? SAMPLE_WIDTH : dgf_pkg::CNT_WIDTH)-1:0]
		cfg_data
);
	import dgf_pkg::*;

	logic                           s1_valid;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           s1_adv;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] result_q;
	cfg_t                           cfg_q;
	logic signed [SAMPLE_WIDTH-1:0] level_th_q;
	logic signed [SAMPLE_WIDTH-1:0] held_q;
	count_t                         run_count_q;
	logic signed [SAMPLE_WIDTH-1:0] step_result;
	logic signed [SAMPLE_WIDTH-1:0] step_held;
	count_t                         step_count;
	logic                           init_wr;
	logic signed [SAMPLE_WIDTH-1:0] init_val;
	logic                           held_out;

	assign s1_adv           = s1_valid && (!out_valid_q || sample_out.ready);
	assign sample_in.ready  = !s1_valid || s1_adv;
	assign sample_out.valid = out_valid_q;
	assign sample_out.data  = result_q;
	assign init_wr          = cfg_we && (cfg_index == REG_INIT);
	assign init_val         = cfg_data[SAMPLE_WIDTH-1:0];
	assign held_out         = s1_adv && !cfg_we && (step_result != sample_s1);

	dgf_step #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_step (
		.cfg          (cfg_q),
		.level_th     (level_th_q),
		.sample       (sample_s1),
		.held         (held_q),
		.run_count    (run_count_q),
		.result       (step_result),
		.held_nxt     (step_held),
		.run_count_nxt(step_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_in.ready) begin
				s1_valid <= sample_in.valid;
			end
			if (!out_valid_q || sample_out.ready) begin
				out_valid_q <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in.valid && sample_in.ready) begin
			sample_s1 <= sample_in.data;
		end
		if (s1_adv) begin
			result_q <= step_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_ABOVE;
			cfg_q.length_th <= LENGTH_RESET;
			level_th_q      <= '0;
			held_q          <= '0;
			run_count_q     <= '0;
		end else begin
			if (init_wr) begin
				held_q      <= init_val;
				run_count_q <= '0;
			end else if (s1_adv) begin
				held_q      <= step_held;
				run_count_q <= step_count;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: cfg_q.mode <= cfg_data[1:0];
					REG_LENGTH: cfg_q.length_th <= cfg_data[CNT_WIDTH-1:0];
					REG_LEVEL: level_th_q <= cfg_data[SAMPLE_WIDTH-1:0];
					default: ;
				endcase
			end
		end
	end

	`DGF_ASSERT_NEXT(a_init_held, init_wr, held_q == $past(init_val), "held level not reloaded")
	`DGF_ASSERT_NEXT(a_init_count, init_wr, run_count_q == '0, "run count not cleared")
	`DGF_ASSERT_NEXT(a_stage_to_out, s1_adv, out_valid_q, "beat lost before the result register")
	`DGF_ASSERT_NEXT(a_hold_counts, held_out, run_count_q != '0, "held level output with zero count")

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the sample deglitch filter: drives sample beats and register
// writes, predicts every output sample and compares each beat as it leaves the block.
// Depends on dgf_pkg, dgf_stream_if and sample_deglitch_filter_top from the RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dgf_pkg::*;

	typedef logic signed [15:0] sample_t;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam count_t COUNT_TOP = 16'hFFFF;
	localparam int LIMIT_CYCLES = 100_000;
	localparam int RX_HOLD_CYCLES = 80;

	class deglitch_scoreboard;
		logic [1:0] mode;
		count_t length_th;
		sample_t level_th;
		sample_t init_level;
		count_t run_count;
		sample_t held_level;
		sample_t expected_samples[$];
		int errors;
		int samples_seen;
		int checked;
		int writes;

		function new();
			mode = MODE_ABOVE;
			length_th = LENGTH_RESET;
			level_th = '0;
			init_level = '0;
			run_count = '0;
			held_level = '0;
			errors = 0;
			samples_seen = 0;
			checked = 0;
			writes = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [15:0] value);
			writes++;
			case (idx)
				REG_MODE: mode = value[1:0];
				REG_LENGTH: length_th = value;
				REG_LEVEL: level_th = value;
				REG_INIT: begin
					init_level = value;
					held_level = value;
					run_count = '0;
				end
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t s);
			sample_t y;
			logic glitch;
			if (mode == MODE_BOTH) begin
				glitch = (s > level_th && held_level < level_th) ||
					(s < level_th && held_level > level_th);
			end else if (mode == MODE_ABOVE) begin
				glitch = s > level_th;
			end else begin
				glitch = s < level_th;
			end
			if (glitch) begin
				if (run_count != COUNT_TOP)
					run_count++;
				if (run_count >= length_th) begin
					y = s;
					if (mode == MODE_BOTH) begin
						held_level = s;
						run_count = '0;
					end
				end else begin
					y = held_level;
				end
			end else begin
				y = s;
				run_count = '0;
				held_level = s;
			end
			samples_seen++;
			expected_samples.push_back(y);
		endfunction

		function void check_result(sample_t actual);
			sample_t want;
			if (expected_samples.size() == 0) begin
				$error("sample_out beat with no sample expected, got %0d", actual);
				errors++;
				return;
			end
			want = expected_samples.pop_front();
			checked++;
			if (actual !== want) begin
				$error("sample_out mismatch: expected %0d, actual %0d", want, actual);
				errors++;
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [15:0] cfg_data;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;
	logic hold_go = 1'b0;
	logic hold_used = 1'b0;
	int cycle_count = 0;
	deglitch_scoreboard sb;

	dgf_stream_if #(.WIDTH(16)) in_if ();
	dgf_stream_if #(.WIDTH(16)) out_if ();

	sample_deglitch_filter_top #(.SAMPLE_WIDTH(16)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (in_if),
		.sample_out (out_if),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used = 1'b1;
			rx_hold = RX_HOLD_CYCLES;
		end
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (in_if.valid && in_if.ready)
			sb.note_sample(in_if.data);
		if (out_if.valid && out_if.ready)
			sb.check_result(out_if.data);
	end

	task automatic write_register(reg_idx_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_register(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [1:0] mode, int length, int level, int init);
		write_register(REG_MODE, {14'($urandom), mode});
		write_register(REG_LENGTH, 16'(length));
		write_register(REG_LEVEL, 16'(level));
		write_register(REG_INIT, 16'(init));
	endtask

	task automatic send_sample(sample_t s);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data <= s;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic play(sample_t seq[$]);
		foreach (seq[i])
			send_sample(seq[i]);
		drain();
	endtask

	function automatic sample_t pick_sample(int side, int lt);
		int lo;
		int hi;
		case (side)
			0: begin
				if (lt == 32767)
					return sample_t'(lt);
				lo = lt + 1;
				hi = ($urandom_range(0, 1) != 0 && lt < 32763) ? lt + 4 : 32767;
				return sample_t'(lo + int'($urandom_range(0, hi - lo)));
			end
			1: begin
				if (lt == -32768)
					return sample_t'(lt);
				hi = lt - 1;
				lo = ($urandom_range(0, 1) != 0 && lt > -32764) ? lt - 4 : -32768;
				return sample_t'(lo + int'($urandom_range(0, hi - lo)));
			end
			2: return sample_t'(lt);
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					default: return sample_t'($urandom);
				endcase
			end
		endcase
	endfunction

	task automatic random_samples(int n);
		int sent;
		int side;
		int run_len;
		int cap;
		int r;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 15);
			if (r == 0) begin
				side = 3;
				run_len = 1;
			end else if (r == 1) begin
				side = 2;
				run_len = 1;
			end else begin
				side = $urandom_range(0, 1);
				cap = (sb.length_th < 6) ? int'(sb.length_th) + 2 : 7;
				run_len = $urandom_range(1, cap);
			end
			for (int k = 0; k < run_len && sent < n; k++) begin
				send_sample(pick_sample(side, sb.level_th));
				sent++;
			end
		end
		drain();
	endtask

	task automatic random_setting();
		int length;
		int level;
		int init;
		case ($urandom_range(0, 5))
			0: length = 0;
			1: length = 1;
			2: length = 65535;
			default: length = $urandom_range(2, 5);
		endcase
		case ($urandom_range(0, 4))
			0: level = -32768;
			1: level = 32767;
			2: level = int'(sample_t'($urandom));
			default: level = int'($urandom_range(0, 200)) - 100;
		endcase
		case ($urandom_range(0, 4))
			0: init = -32768;
			1: init = 32767;
			2: init = level;
			default: init = int'(sample_t'($urandom));
		endcase
		configure(2'($urandom_range(0, 3)), length, level, init);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_if.valid <= 1'b0;
		in_if.data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		play('{16'sd0, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sh8000, 16'sh7FFF, 16'sd0});
		configure(MODE_BELOW, 0, 32767, 32767);
		play('{-16'sd5, 16'sh8000, 16'sh7FFF});
		configure(MODE_BOTH, 2, 100, 0);
		play('{16'sd200, 16'sd50, 16'sd200, 16'sd200, 16'sd100, 16'sh7FFF, 16'sh8000});
		configure(MODE_UNUSED, 1, 0, -32768);
		play('{-16'sd1, 16'sd5, 16'sh8000});

		for (int phase = 0; phase < 9; phase++) begin
			if (phase < 3) begin
				tx_idle_pct = 12;
				rx_idle_pct = 76;
			end else if (phase < 6) begin
				tx_idle_pct = 76;
				rx_idle_pct = 12;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			random_setting();
			if (phase == 6)
				hold_go = 1'b1;
			random_samples(45);
		end

		$display("Checked %0d output samples from %0d input beats over %0d register writes,",
			sb.checked, sb.samples_seen, sb.writes);
		$display("covering all modes, threshold extremes, idle patterns and a long output stall.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
